[hw/rtl/cmpsh_pkg.sv]
// Package for the compass heading block: widths, fixed-point constants,
// the CORDIC arctangent table and the item type passed along the cell chain.
// No dependencies; every other file of the block imports it.
package cmpsh_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int STEP_W       = 5;

	localparam int MAG_W    = 12;
	localparam int DECL_W   = 19;
	localparam int HEAD_W   = 16;
	localparam int PRESCALE = 20;
	localparam int XY_W     = 36;
	localparam int Z_W      = 28;
	localparam int H_W      = 30;
	localparam int HU_W     = 27;
	localparam int PROD_W   = 56;
	localparam int DEG_SHIFT = 40;

	localparam int PADDR_W = 3;
	localparam logic REG_DECL = 1'b0;

	localparam logic signed [Z_W-1:0]    HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [H_W-1:0]    TWO_PI_Q24  = 30'sd105414357;
	localparam logic signed [DECL_W-1:0] DECL_LIMIT  = 19'sd205887;
	localparam logic [PROD_W-1:0]        DEG_MUL     = 56'd375493621;
	localparam logic [HEAD_W:0]          HEAD_MAX    = 17'd36000;

	typedef struct packed {
		logic                   vld;
		logic                   zero;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	// Arctangent of 2^-i in radians times 2^24, rounded to nearest.
	function automatic logic [23:0] atan_q24(input logic [STEP_W-1:0] idx);
		logic [23:0] v;
		unique case (idx)
			5'd0:    v = 24'd13176795;
			5'd1:    v = 24'd7778716;
			5'd2:    v = 24'd4110060;
			5'd3:    v = 24'd2086331;
			5'd4:    v = 24'd1047214;
			5'd5:    v = 24'd524117;
			5'd6:    v = 24'd262123;
			5'd7:    v = 24'd131069;
			5'd8:    v = 24'd65536;
			5'd9:    v = 24'd32768;
			5'd10:   v = 24'd16384;
			5'd11:   v = 24'd8192;
			5'd12:   v = 24'd4096;
			5'd13:   v = 24'd2048;
			5'd14:   v = 24'd1024;
			5'd15:   v = 24'd512;
			5'd16:   v = 24'd256;
			5'd17:   v = 24'd128;
			5'd18:   v = 24'd64;
			5'd19:   v = 24'd32;
			5'd20:   v = 24'd16;
			5'd21:   v = 24'd8;
			5'd22:   v = 24'd4;
			5'd23:   v = 24'd2;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/compass_heading_from_field.sv]
// Compass heading from a level magnetometer reading.
// Input items arrive on s_tvalid/s_tready/s_tdata, each a signed X and Y
// field count; every item gives one heading item on m_tvalid/m_tready/m_tdata
// in hundredths of a degree, 0 to 36000, with the declination register added.
// The angle comes from a chain of CORDIC cells, one iteration per cell and
// register, behind a quarter-turn entry cell; then come a wrap stage, a
// constant-multiply stage and the output register.
// An accepted item passes the entry cell, the cell chain, the wrap and
// multiply stages and the output register to m_tvalid. One item is taken per
// cycle while the output is not stalled; the cell chain length sets the latency, not the throughput.
// When the receiver holds m_tready low with a result waiting, the whole chain
// freezes and s_tready falls; it rises again the cycle the result is taken.
// Reset clears all stage valid bits and the declination register to zero.
// The declination register sits at APB byte address 0; the user must write it
// only while no items are in flight, as the block itself does not enforce this.
// Depends on cmpsh_pkg, cmpsh_prerot, cmpsh_cell and cmpsh_post.
module compass_heading_from_field
	import cmpsh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,   // [11:0] mag_x, [23:12] mag_y
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [HEAD_W-1:0]  m_tdata,   // [15:0] heading_centideg
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic                     en;
	logic                     cfg_wr;
	logic signed [DECL_W-1:0] decl_q;
	cordic_t                  chain [0:NUM_CELLS];
	logic                     post_vld;
	logic [PROD_W-1:0]        post_prod;
	logic [PROD_W:0]          rnd;
	logic [HEAD_W:0]          cd;
	logic [HEAD_W-1:0]        head;
	logic                     m_tvalid_q;
	logic [HEAD_W-1:0]        m_tdata_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_DECL);
	assign prdata   = (paddr[2] == REG_DECL) ? {{(32-DECL_W){1'b0}}, decl_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
		end else if (cfg_wr) begin
			decl_q <= pwdata[DECL_W-1:0];
		end
	end

	cmpsh_prerot u_prerot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.mag_x   (s_tdata[11:0]),
		.mag_y   (s_tdata[23:12]),
		.cell_s0 (chain[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		cmpsh_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.step    (STEP_W'(i)),
			.cell_in (chain[i]),
			.cell_q  (chain[i+1])
		);
	end

	cmpsh_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cell_in     (chain[NUM_CELLS]),
		.declination (decl_q),
		.vld_s2      (post_vld),
		.prod_s2     (post_prod)
	);

	// Round to nearest, then keep within a full turn.
	always_comb begin
		rnd  = {1'b0, post_prod} + ((PROD_W+1)'(1) << (DEG_SHIFT - 1));
		cd   = rnd[DEG_SHIFT +: (HEAD_W+1)];
		head = (cd > HEAD_MAX) ? HEAD_MAX[HEAD_W-1:0] : cd[HEAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= post_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= head;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata <= HEAD_MAX[HEAD_W-1:0]))
		else $error("heading above a full turn");

	a_prerot_right: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].vld |-> !chain[0].x[XY_W-1])
		else $error("entry cell left x negative");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(post_vld) && $stable(chain[NUM_CELLS].vld)))
		else $error("pipeline moved during a stall");

endmodule

[hw/rtl/cmpsh_prerot.sv]
// Entry cell of the CORDIC chain: scales the reading to the working format
// and turns vectors in the left half plane by a quarter turn.
// Depends on cmpsh_pkg.
module cmpsh_prerot
	import cmpsh_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [MAG_W-1:0] mag_x,
	input  logic signed [MAG_W-1:0] mag_y,
	output cordic_t                 cell_s0
);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	cordic_t                nxt;

	always_comb begin
		xs = {{(XY_W-MAG_W-PRESCALE){mag_x[MAG_W-1]}}, mag_x, {PRESCALE{1'b0}}};
		ys = {{(XY_W-MAG_W-PRESCALE){mag_y[MAG_W-1]}}, mag_y, {PRESCALE{1'b0}}};
		nxt.vld  = in_vld;
		nxt.zero = (mag_x == '0) && (mag_y == '0);
		if (!xs[XY_W-1]) begin
			nxt.x = xs;
			nxt.y = ys;
			nxt.z = '0;
		end else if (!ys[XY_W-1]) begin
			nxt.x = ys;
			nxt.y = -xs;
			nxt.z = HALF_PI_Q24;
		end else begin
			nxt.x = -ys;
			nxt.y = xs;
			nxt.z = -HALF_PI_Q24;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s0 <= '0;
		end else if (en) begin
			cell_s0 <= nxt;
		end
	end

endmodule

[hw/rtl/cmpsh_cell.sv]
// One CORDIC vectoring iteration with its own register stage.
// The step index is tied to a constant by the instantiating chain.
// Depends on cmpsh_pkg.
module cmpsh_cell
	import cmpsh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  cordic_t           cell_in,
	output cordic_t           cell_q
);

	logic signed [XY_W-1:0] xsh;
	logic signed [XY_W-1:0] ysh;
	logic signed [Z_W-1:0]  ang;
	cordic_t                nxt;

	always_comb begin
		// Arithmetic shifts round towards minus infinity.
		xsh = cell_in.x >>> step;
		ysh = cell_in.y >>> step;
		ang = {{(Z_W-24){1'b0}}, atan_q24(step)};
		nxt.vld  = cell_in.vld;
		nxt.zero = cell_in.zero;
		if (!cell_in.y[XY_W-1]) begin
			nxt.x = cell_in.x + ysh;
			nxt.y = cell_in.y - xsh;
			nxt.z = cell_in.z + ang;
		end else begin
			nxt.x = cell_in.x - ysh;
			nxt.y = cell_in.y + xsh;
			nxt.z = cell_in.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

endmodule

[hw/rtl/cmpsh_post.sv]
// Back end of the pipeline: adds the saturated declination, wraps into
// [0, 2*pi] and scales radians to hundredths of a degree by a constant multiply.
// Depends on cmpsh_pkg.
module cmpsh_post
	import cmpsh_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cordic_t                  cell_in,
	input  logic signed [DECL_W-1:0] declination,
	output logic                     vld_s2,
	output logic [PROD_W-1:0]        prod_s2
);

	logic signed [DECL_W-1:0] dsat;
	logic signed [Z_W-1:0]    ang;
	logic signed [H_W-1:0]    h0;
	logic signed [H_W-1:0]    h1;
	logic signed [H_W-1:0]    h2;
	logic signed [H_W-1:0]    h3;
	logic                     vld_s1;
	logic [HU_W-1:0]          h_s1;

	always_comb begin
		priority if (declination > DECL_LIMIT) begin
			dsat = DECL_LIMIT;
		end else if (declination < -DECL_LIMIT) begin
			dsat = -DECL_LIMIT;
		end else begin
			dsat = declination;
		end
		ang = cell_in.zero ? '0 : cell_in.z;
		h0  = {{(H_W-Z_W){ang[Z_W-1]}}, ang}
			+ {{(H_W-DECL_W-8){dsat[DECL_W-1]}}, dsat, 8'd0};
		h1  = h0[H_W-1] ? h0 + TWO_PI_Q24 : h0;
		h2  = (h1 > TWO_PI_Q24) ? h1 - TWO_PI_Q24 : h1;
		priority if (h2[H_W-1]) begin
			h3 = '0;
		end else if (h2 > TWO_PI_Q24) begin
			h3 = TWO_PI_Q24;
		end else begin
			h3 = h2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cell_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1    <= h3[HU_W-1:0];
			prod_s2 <= PROD_W'(h_s1) * DEG_MUL;
		end
	end

endmodule
